FILE: design/srpt_scheduler_queue_top_assert.svh
// assertion macros shared by the scheduler queue checker
`ifndef SRPT_SCHEDULER_QUEUE_TOP_ASSERT_SVH
`define SRPT_SCHEDULER_QUEUE_TOP_ASSERT_SVH

// a condition that holds at every clock edge out of reset
`define SRPT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// a condition in one cycle that forces another in the next
`define SRPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/srpt_sq_pkg.sv
// types and constants for the shortest remaining time scheduler queue
package srpt_sq_pkg;

    localparam int ID_W       = 8;
    localparam int LEN_W      = 16;
    localparam int WAIT_W     = 32;
    localparam int IN_TDATA_W = 24;

    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    // one queued job as held in the entry store
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  run;
        logic [WAIT_W-1:0] wait_cnt;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // tick sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PROC,
        ST_TAIL,
        ST_DONE
    } state_t;

endpackage

FILE: design/srpt_scheduler_queue_top.sv
// shortest remaining processing time scheduler queue, sweep based
//
// usage:
//   slave channel: one transaction is one scheduler tick. tuser[0] flags an
//   arriving job, tdata carries its id and length (a length of 0 runs as 1).
//   master channel: one result transaction per tick with busy flag, running
//   id, completion flag and wait count, drop flag and the queue count.
// operation:
//   the queue lives in a two bank entry memory. each tick sweeps the stored
//   jobs in order through one shared subtract/compare and increment unit,
//   merges the arrival in at its place, advances the head, ages the rest and
//   writes the stream into the other bank; the banks then swap.
// sequencing:
//   each stored job is read from memory in ST_READ and passed through the
//   unit in ST_PROC; an arrival that lands in front of a stored job takes an
//   extra ST_PROC step, and ST_TAIL and ST_DONE close the tick. s_axis_tready
//   is high only while the sequencer is idle.
// reset: the queue is empty, no result is pending; memory contents are
//   never read before being written.
// stall: a result waits in the output register; the next tick is taken
//   meanwhile, and its result is held back until the register is free.
module srpt_scheduler_queue_top #(
    parameter int  QUEUE_DEPTH = 16,
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1),
    localparam int OUT_W       = 43 + COUNT_W,
    localparam int M_TDATA_W   = ((OUT_W + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // new_id [7:0], new_length [23:8]
    input  logic [srpt_sq_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // arrive_valid [0]
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // busy_res [0], running_id [8:1], done_res [9], done_wait [41:10],
    // dropped [42], queue_count [42+COUNT_W:43], zero padding above
    output logic [M_TDATA_W-1:0]              m_axis_tdata
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int AW    = IDX_W + 1;
    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(QUEUE_DEPTH);

    // sequencer and control state
    srpt_sq_pkg::state_t state_reg, state_next;
    logic [COUNT_W-1:0] occ_reg, occ_next;
    logic [COUNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic [COUNT_W-1:0] wr_cnt_reg, wr_cnt_next;
    logic               bank_reg, bank_next;
    logic               ins_pend_reg, ins_pend_next;
    logic               head_seen_reg, head_seen_next;
    logic               out_valid_reg, out_valid_next;

    // tick payload and result
    logic [srpt_sq_pkg::ID_W-1:0]   new_id_reg, new_id_next;
    logic [srpt_sq_pkg::LEN_W-1:0]  new_len_reg, new_len_next;
    logic                           busy_reg, busy_next;
    logic [srpt_sq_pkg::ID_W-1:0]   run_id_reg, run_id_next;
    logic                           done_reg, done_next;
    logic [srpt_sq_pkg::WAIT_W-1:0] wait_out_reg, wait_out_next;
    logic                           drop_reg, drop_next;
    logic [OUT_W-1:0]               out_data_reg, out_data_next;

    // entry memory, two banks of 2**IDX_W entries, each holding up to QUEUE_DEPTH jobs
    logic [srpt_sq_pkg::ENTRY_W-1:0] mem [0:(2**AW)-1];
    srpt_sq_pkg::entry_t rdata_reg;

    // control from the sequencer
    logic rd_en;
    logic emit_en;
    logic emit_new;
    logic tick_acc;
    logic out_load;

    // shared unit signals
    srpt_sq_pkg::entry_t emit_entry;
    srpt_sq_pkg::entry_t new_entry;
    srpt_sq_pkg::entry_t wdata;
    logic [srpt_sq_pkg::LEN_W-1:0]  rem;
    logic                           rem_lt;
    logic                           rem_eq;
    logic                           ins_here;
    logic                           last_elem;
    logic [srpt_sq_pkg::LEN_W-1:0]  run_inc;
    logic [srpt_sq_pkg::WAIT_W-1:0] wait_inc;
    logic                           is_head;
    logic                           head_done;
    logic                           wr_en;
    logic [AW-1:0]                  raddr;
    logic [AW-1:0]                  waddr;

    // placement compare against the stored job being swept
    always_comb
    begin
        rem      = rdata_reg.len - rdata_reg.run;
        rem_lt   = (rem < new_len_reg);
        rem_eq   = (rem == new_len_reg);
        // in front of the head only when strictly shorter, else before the
        // first later job that is not shorter
        if (rd_cnt_reg == '0)
        begin
            ins_here = ins_pend_reg && !rem_lt && !rem_eq;
        end
        else
        begin
            ins_here = ins_pend_reg && !rem_lt;
        end
        last_elem = (rd_cnt_reg == (occ_reg - COUNT_W'(1)));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srpt_sq_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = (occ_reg == '0) ? srpt_sq_pkg::ST_TAIL
                                                 : srpt_sq_pkg::ST_READ;
                end
            end
            srpt_sq_pkg::ST_READ:
            begin
                state_next = srpt_sq_pkg::ST_PROC;
            end
            srpt_sq_pkg::ST_PROC:
            begin
                priority if (ins_here)
                begin
                    state_next = srpt_sq_pkg::ST_PROC;
                end
                else if (last_elem)
                begin
                    state_next = srpt_sq_pkg::ST_TAIL;
                end
                else
                begin
                    state_next = srpt_sq_pkg::ST_READ;
                end
            end
            srpt_sq_pkg::ST_TAIL:
            begin
                state_next = srpt_sq_pkg::ST_DONE;
            end
            srpt_sq_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = srpt_sq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srpt_sq_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        rd_en    = 1'b0;
        emit_en  = 1'b0;
        emit_new = 1'b0;
        tick_acc = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            srpt_sq_pkg::ST_IDLE:
            begin
                tick_acc = s_axis_tvalid;
            end
            srpt_sq_pkg::ST_READ:
            begin
                rd_en = 1'b1;
            end
            srpt_sq_pkg::ST_PROC:
            begin
                emit_en  = 1'b1;
                emit_new = ins_here;
            end
            srpt_sq_pkg::ST_TAIL:
            begin
                emit_en  = ins_pend_reg;
                emit_new = 1'b1;
            end
            srpt_sq_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == srpt_sq_pkg::ST_IDLE);

    // shared tick unit: advance the head, age every other job
    always_comb
    begin
        new_entry.id       = new_id_reg;
        new_entry.len      = new_len_reg;
        new_entry.run      = '0;
        new_entry.wait_cnt = '0;
        emit_entry = emit_new ? new_entry : rdata_reg;
        run_inc    = emit_entry.run + srpt_sq_pkg::LEN_W'(1);
        wait_inc   = (emit_entry.wait_cnt == srpt_sq_pkg::WAIT_MAX)
                     ? emit_entry.wait_cnt
                     : emit_entry.wait_cnt + srpt_sq_pkg::WAIT_W'(1);
        is_head    = !head_seen_reg;
        head_done  = is_head && (run_inc >= emit_entry.len);
        wr_en      = emit_en && !head_done;
        wdata      = emit_entry;
        if (is_head)
        begin
            wdata.run = run_inc;
        end
        else
        begin
            wdata.wait_cnt = wait_inc;
        end
        raddr = {bank_reg, rd_cnt_reg[IDX_W-1:0]};
        waddr = {~bank_reg, wr_cnt_reg[IDX_W-1:0]};
    end

    // datapath and counter next values
    always_comb
    begin
        occ_next       = occ_reg;
        rd_cnt_next    = rd_cnt_reg;
        wr_cnt_next    = wr_cnt_reg;
        bank_next      = bank_reg;
        ins_pend_next  = ins_pend_reg;
        head_seen_next = head_seen_reg;
        out_valid_next = out_valid_reg;
        new_id_next    = new_id_reg;
        new_len_next   = new_len_reg;
        busy_next      = busy_reg;
        run_id_next    = run_id_reg;
        done_next      = done_reg;
        wait_out_next  = wait_out_reg;
        drop_next      = drop_reg;
        out_data_next  = out_data_reg;

        // latch a new tick
        if (tick_acc)
        begin
            ins_pend_next  = s_axis_tuser[0] && (occ_reg != DEPTH_C);
            drop_next      = s_axis_tuser[0] && (occ_reg == DEPTH_C);
            new_id_next    = s_axis_tdata[7:0];
            new_len_next   = (s_axis_tdata[23:8] == '0) ? srpt_sq_pkg::LEN_W'(1)
                                                        : s_axis_tdata[23:8];
            rd_cnt_next    = '0;
            wr_cnt_next    = '0;
            head_seen_next = 1'b0;
            busy_next      = 1'b0;
            run_id_next    = '0;
            done_next      = 1'b0;
            wait_out_next  = '0;
        end

        // one job leaves the shared unit
        if (emit_en)
        begin
            head_seen_next = 1'b1;
            if (is_head)
            begin
                busy_next   = 1'b1;
                run_id_next = emit_entry.id;
            end
            if (head_done)
            begin
                done_next     = 1'b1;
                wait_out_next = emit_entry.wait_cnt;
            end
            if (wr_en)
            begin
                wr_cnt_next = wr_cnt_reg + COUNT_W'(1);
            end
            if (emit_new)
            begin
                ins_pend_next = 1'b0;
            end
            else
            begin
                rd_cnt_next = rd_cnt_reg + COUNT_W'(1);
            end
        end

        // result register
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {wr_cnt_reg, drop_reg, wait_out_reg, done_reg,
                              run_id_reg, busy_reg};
            occ_next       = wr_cnt_reg;
            bank_next      = ~bank_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srpt_sq_pkg::ST_IDLE;
            occ_reg       <= '0;
            rd_cnt_reg    <= '0;
            wr_cnt_reg    <= '0;
            bank_reg      <= 1'b0;
            ins_pend_reg  <= 1'b0;
            head_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            rd_cnt_reg    <= rd_cnt_next;
            wr_cnt_reg    <= wr_cnt_next;
            bank_reg      <= bank_next;
            ins_pend_reg  <= ins_pend_next;
            head_seen_reg <= head_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        new_id_reg   <= new_id_next;
        new_len_reg  <= new_len_next;
        busy_reg     <= busy_next;
        run_id_reg   <= run_id_next;
        done_reg     <= done_next;
        wait_out_reg <= wait_out_next;
        drop_reg     <= drop_next;
        out_data_reg <= out_data_next;
    end

    // entry memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_data_reg);

endmodule

FILE: design/srpt_sq_checker.sv
// port level checks for the scheduler queue, bound to the top level
`include "srpt_scheduler_queue_top_assert.svh"

module srpt_sq_checker #(
    parameter int  QUEUE_DEPTH = 16,
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1),
    localparam int OUT_W       = 43 + COUNT_W,
    localparam int M_TDATA_W   = ((OUT_W + 7) / 8) * 8
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [M_TDATA_W-1:0]              m_axis_tdata
);

    localparam logic [COUNT_W-1:0] DEPTH_C   = COUNT_W'(QUEUE_DEPTH);
    localparam logic [COUNT_W-1:0] DEPTH_M1  = COUNT_W'(QUEUE_DEPTH - 1);

    // result fields
    logic               res_busy;
    logic               res_done;
    logic               res_drop;
    logic [40:0]        res_idle_bits;
    logic [COUNT_W-1:0] res_count;

    assign res_busy      = m_axis_tdata[0];
    assign res_done      = m_axis_tdata[9];
    assign res_drop      = m_axis_tdata[42];
    assign res_idle_bits = m_axis_tdata[41:1];
    assign res_count     = m_axis_tdata[42+COUNT_W:43];

    // a tick transaction is never followed by another in the next cycle
    `SRPT_ASSERT_NEXT(a_in_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input taken in back to back cycles")

    // a pending result is not withdrawn
    `SRPT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
        "result withdrawn while stalled")

    // completion only for a job that ran, idle ticks report nothing
    `SRPT_ASSERT_ALWAYS(a_done_busy, !m_axis_tvalid || !res_done || res_busy,
        "completion without a running job")
    `SRPT_ASSERT_ALWAYS(a_idle_zero, !m_axis_tvalid || res_busy || (res_idle_bits == '0),
        "idle tick with nonzero id or wait")

    // a drop only happens on a full queue, which loses at most the head
    `SRPT_ASSERT_ALWAYS(a_drop_full,
        !m_axis_tvalid || !res_drop || (res_count == DEPTH_C) || (res_count == DEPTH_M1),
        "arrival dropped while queue not full")

endmodule

bind srpt_scheduler_queue_top srpt_sq_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_srpt_sq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
